// File: rtl/core/rpc_pkg.sv
// rpc_pkg: shared types, constants and microprogram for the palette crossfade core
package rpc_pkg;

	localparam int PALETTE_DEPTH = 10;
	localparam int PAL_IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int PAL_CNT_W = $clog2(PALETTE_DEPTH + 1);

	localparam int CHAN_W = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int FADE_W = 16;
	localparam int STEP_W = 32;
	localparam int PROD_W = CHAN_W + FADE_W;

	// shared divider: 32-bit dividend, 16-bit divisor, one quotient bit per cycle
	localparam int DVD_W = 32;
	localparam int DVS_W = 16;
	localparam int DCNT_W = $clog2(DVD_W + 1);
	localparam logic [DCNT_W-1:0] LERP_STEPS = DCNT_W'(PROD_W);
	localparam logic [DCNT_W-1:0] MOD_STEPS = DCNT_W'(STEP_W);

	localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(1000);

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_APPEND = 1'b1;

	typedef struct packed {
		logic action;
		logic [CHAN_W-1:0] in_red;
		logic [CHAN_W-1:0] in_green;
		logic [CHAN_W-1:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
		logic advanced;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic step;
		logic [DCNT_W-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic last;
	} div_sts_t;

	// microcode
	localparam int UPC_W = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_MUL,
		OP_DIV_STEP,
		OP_CH_DONE,
		OP_ELAPSED,
		OP_MOD_LOAD,
		OP_NEXT,
		OP_OUT
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_ITEM,
		COND_DIV_MORE,
		COND_CH_MORE,
		COND_NO_NEXT,
		COND_OUT_BUSY
	} ucond_t;

	typedef struct packed {
		uop_t op;
		ucond_t cond;
		logic [UPC_W-1:0] target;
	} uword_t;

	localparam logic [UPC_W-1:0] UA_WAIT = UPC_W'(0);
	localparam logic [UPC_W-1:0] UA_MUL = UPC_W'(1);
	localparam logic [UPC_W-1:0] UA_LDIV = UPC_W'(2);
	localparam logic [UPC_W-1:0] UA_CHDONE = UPC_W'(3);
	localparam logic [UPC_W-1:0] UA_ELAPSED = UPC_W'(4);
	localparam logic [UPC_W-1:0] UA_MODLD = UPC_W'(5);
	localparam logic [UPC_W-1:0] UA_MDIV = UPC_W'(6);
	localparam logic [UPC_W-1:0] UA_NEXT = UPC_W'(7);
	localparam logic [UPC_W-1:0] UA_OUT = UPC_W'(8);
	localparam logic [UPC_W-1:0] UA_RET = UPC_W'(9);

	function automatic uword_t urom(input logic [UPC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			UA_WAIT: w = '{OP_WAIT, COND_NO_ITEM, UA_WAIT};
			UA_MUL: w = '{OP_MUL, COND_NEVER, UA_WAIT};
			UA_LDIV: w = '{OP_DIV_STEP, COND_DIV_MORE, UA_LDIV};
			UA_CHDONE: w = '{OP_CH_DONE, COND_CH_MORE, UA_MUL};
			UA_ELAPSED: w = '{OP_ELAPSED, COND_NO_NEXT, UA_OUT};
			UA_MODLD: w = '{OP_MOD_LOAD, COND_NEVER, UA_WAIT};
			UA_MDIV: w = '{OP_DIV_STEP, COND_DIV_MORE, UA_MDIV};
			UA_NEXT: w = '{OP_NEXT, COND_NEVER, UA_WAIT};
			UA_OUT: w = '{OP_OUT, COND_OUT_BUSY, UA_OUT};
			UA_RET: w = '{OP_NOP, COND_ALWAYS, UA_WAIT};
			default: w = '{OP_NOP, COND_ALWAYS, UA_WAIT};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/rgb_palette_crossfade_core.sv
// rgb_palette_crossfade_core: microcoded palette crossfade sequencer
// each item is processed by the shared bit-serial divider, once per channel, and a tick
// that ends a fade with a non-empty palette adds a division for the next palette index
// (24 steps per channel, 32 for the palette index); a new item waits until the sequencer is idle
// reset: fade time 1000, palette empty, colors black; palette contents unset
// a new item is accepted while the previous result still waits in the output register
module rgb_palette_crossfade_core import rpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [FADE_W-1:0] cfg_data
);

	logic [UPC_W-1:0] upc_q;
	uword_t uw;
	logic branch;

	logic [FADE_W-1:0] fade_q;
	logic [PAL_CNT_W-1:0] count_q;
	logic [STEP_W-1:0] step_q;
	logic [FADE_W-1:0] elapsed_q;
	logic [COLOR_W-1:0] from_q;
	logic [COLOR_W-1:0] to_q;
	logic [COLOR_W-1:0] col_q;
	logic [FADE_W-1:0] t_q;
	logic tick_q;
	logic adv_q;
	logic neg_q;
	logic [1:0] ch_q;

	logic [COLOR_W-1:0] pal_q [PALETTE_DEPTH];

	logic [FADE_W-1:0] fade_eff;
	logic [FADE_W:0] elapsed_inc;
	logic accept;
	logic out_open;
	logic fade_end;
	logic [CHAN_W-1:0] from_ch;
	logic [CHAN_W-1:0] to_ch;
	logic [CHAN_W:0] diff;
	logic [CHAN_W-1:0] mag;
	logic [PROD_W-1:0] prod;
	logic [CHAN_W-1:0] quo8;
	logic [CHAN_W-1:0] ch_val;

	div_ctl_t div_ctl;
	div_sts_t div_sts;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic [DVD_W-1:0] div_quo;
	logic [DVS_W-1:0] div_rem;

	assign uw = urom(upc_q);

	assign cfg_ready = 1'b1;
	assign item_stall = (uw.op != OP_WAIT);
	assign accept = item_valid && !item_stall;
	assign out_open = !result_valid || !result_stall;

	assign fade_eff = (fade_q == '0) ? FADE_W'(1) : fade_q;
	assign elapsed_inc = {1'b0, elapsed_q} + (FADE_W+1)'(1);
	assign fade_end = tick_q && (t_q >= fade_eff);

	// channel select, red first
	always_comb begin
		unique case (ch_q)
			2'd0: begin
				from_ch = from_q[23:16];
				to_ch = to_q[23:16];
			end
			2'd1: begin
				from_ch = from_q[15:8];
				to_ch = to_q[15:8];
			end
			default: begin
				from_ch = from_q[7:0];
				to_ch = to_q[7:0];
			end
		endcase
	end

	assign diff = {1'b0, to_ch} - {1'b0, from_ch};
	assign mag = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
	assign prod = PROD_W'(mag) * PROD_W'(t_q);

	// quotient never exceeds 255 since t is clamped to the fade time
	assign quo8 = div_quo[CHAN_W-1:0];
	assign ch_val = neg_q ? (from_ch - quo8) : (from_ch + quo8);

	always_comb begin
		div_ctl = '0;
		div_dvd = '0;
		div_dvs = '0;
		unique case (uw.op)
			OP_MUL: begin
				div_ctl.load = 1'b1;
				div_ctl.steps = LERP_STEPS;
				div_dvd = {prod, (DVD_W-PROD_W)'(0)};
				div_dvs = DVS_W'(fade_eff);
			end
			OP_MOD_LOAD: begin
				div_ctl.load = 1'b1;
				div_ctl.steps = MOD_STEPS;
				div_dvd = DVD_W'(step_q);
				div_dvs = DVS_W'(count_q);
			end
			OP_DIV_STEP: div_ctl.step = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		unique case (uw.cond)
			COND_NEVER: branch = 1'b0;
			COND_ALWAYS: branch = 1'b1;
			COND_NO_ITEM: branch = !accept;
			COND_DIV_MORE: branch = !div_sts.last;
			COND_CH_MORE: branch = (ch_q != 2'd2);
			COND_NO_NEXT: branch = !(fade_end && count_q != '0);
			COND_OUT_BUSY: branch = !out_open;
			default: branch = 1'b0;
		endcase
	end

	rpc_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.dividend(div_dvd),
		.divisor(div_dvs),
		.sts(div_sts),
		.quotient(div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_WAIT;
			fade_q <= FADE_RESET;
			count_q <= '0;
			step_q <= '0;
			elapsed_q <= '0;
			from_q <= '0;
			to_q <= '0;
			col_q <= '0;
			t_q <= '0;
			tick_q <= 1'b0;
			adv_q <= 1'b0;
			neg_q <= 1'b0;
			ch_q <= '0;
			result_valid <= 1'b0;
		end else begin
			upc_q <= branch ? uw.target : upc_q + UPC_W'(1);

			if (cfg_valid && cfg_ready) begin
				fade_q <= cfg_data;
			end

			if (uw.op == OP_OUT && out_open) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end

			unique case (uw.op)
				OP_WAIT: begin
					if (accept) begin
						tick_q <= (item.action == ACT_TICK);
						adv_q <= 1'b0;
						ch_q <= '0;
						if (item.action == ACT_APPEND) begin
							t_q <= (elapsed_q < fade_eff) ? elapsed_q : fade_eff;
							if (count_q < PAL_CNT_W'(PALETTE_DEPTH)) begin
								count_q <= count_q + PAL_CNT_W'(1);
							end
						end else begin
							t_q <= (elapsed_inc > {1'b0, fade_eff}) ? fade_eff
								: elapsed_inc[FADE_W-1:0];
						end
					end
				end
				OP_MUL: neg_q <= diff[CHAN_W];
				OP_CH_DONE: begin
					unique case (ch_q)
						2'd0: col_q[23:16] <= ch_val;
						2'd1: col_q[15:8] <= ch_val;
						default: col_q[7:0] <= ch_val;
					endcase
					ch_q <= ch_q + 2'd1;
				end
				OP_ELAPSED: begin
					if (fade_end) begin
						from_q <= to_q;
						elapsed_q <= '0;
						adv_q <= 1'b1;
					end else if (tick_q) begin
						elapsed_q <= t_q;
					end
				end
				OP_NEXT: begin
					to_q <= pal_q[div_rem[PAL_IDX_W-1:0]];
					step_q <= step_q + STEP_W'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && item.action == ACT_APPEND
				&& count_q < PAL_CNT_W'(PALETTE_DEPTH)) begin
			pal_q[count_q[PAL_IDX_W-1:0]] <= {item.in_red, item.in_green, item.in_blue};
		end
		if (uw.op == OP_OUT && out_open) begin
			result.out_red <= col_q[23:16];
			result.out_green <= col_q[15:8];
			result.out_blue <= col_q[7:0];
			result.advanced <= adv_q;
		end
	end

endmodule

// File: rtl/core/rpc_divider.sv
// rpc_divider: restoring unsigned divider, one quotient bit per cycle while step is asserted
module rpc_divider import rpc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_ctl_t ctl,
	input logic [DVD_W-1:0] dividend,
	input logic [DVS_W-1:0] divisor,
	output div_sts_t sts,
	output logic [DVD_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0] shifted;
	logic [DVS_W+1:0] trial;

	assign shifted = {rem_q, dvd_q[DVD_W-1]};
	assign trial = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= ctl.steps;
		end else if (ctl.step && cnt_q != '0) begin
			cnt_q <= cnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (ctl.step && cnt_q != '0) begin
			// no borrow: divisor fits, keep the difference
			if (!trial[DVS_W+1]) begin
				rem_q <= trial[DVS_W-1:0];
			end else begin
				rem_q <= shifted[DVS_W-1:0];
			end
			dvd_q <= {dvd_q[DVD_W-2:0], ~trial[DVS_W+1]};
		end
	end

	assign sts.last = (cnt_q == DCNT_W'(1));
	assign quotient = dvd_q;
	assign remainder = rem_q;

endmodule
